FILE: src/rate_gyro_angle_integrator_macros.svh
// Assertion macros for the rate gyro angle integrator.
// Used by the top level; expects clk and arst_n in scope.
`ifndef RATE_GYRO_ANGLE_INTEGRATOR_MACROS_SVH
`define RATE_GYRO_ANGLE_INTEGRATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RGAI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RGAI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rgai_pkg.sv
// Package for the rate gyro angle integrator: field widths, command and
// register codes, and derived arithmetic constants. No dependencies.
package rgai_pkg;

	// Field widths.
	localparam int SAMPLE_W = 12;
	localparam int TICK_W   = 32;
	localparam int GAIN_W   = 32;
	localparam int DBAND_W  = 12;
	localparam int ANGLE_W  = 33;

	// Calibration.
	localparam int ADC_BITS    = SAMPLE_W;
	localparam int CAL_SAMPLES = 100;
	localparam int CAL_W       = $clog2(CAL_SAMPLES + 1);
	localparam int SUM_W       = ADC_BITS + CAL_W;
	localparam int FRAC_W      = 8;
	localparam int ZERO_W      = ADC_BITS + FRAC_W;
	localparam int DIVD_W      = SUM_W + FRAC_W;

	// Serial multiplier: |rate| * dt, then that product * gain.
	localparam int RATE_W   = ADC_BITS;
	localparam int DT_W     = 16;
	localparam int MCAND_W  = RATE_W + DT_W;
	localparam int PROD_W   = MCAND_W + GAIN_W;
	localparam int P1_LO    = GAIN_W - RATE_W;
	localparam int MAG_SH   = 8;
	localparam int ACC_W    = ANGLE_W + 2;
	localparam int CNT_MAX  = (GAIN_W > DIVD_W) ? GAIN_W : DIVD_W;
	localparam int CNT_W    = $clog2(CNT_MAX);

	// 360 degrees in Q9.24.
	localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(360) << 24;

	// Commands.
	typedef enum logic [1:0] {
		CMD_CAL     = 2'd0,
		CMD_MEASURE = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEAD_BAND = 1'b0,
		REG_RATE_GAIN = 1'b1
	} reg_idx_t;

endpackage

FILE: src/rgai_item_if.sv
// Input item channel of the rate gyro angle integrator.
// Depends on rgai_pkg.
interface rgai_item_if;
	import rgai_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          cmd;
	logic [SAMPLE_W-1:0] sample;
	logic [TICK_W-1:0]   tick_ms;

	modport source(output valid, cmd, sample, tick_ms, input ready);
	modport sink(input valid, cmd, sample, tick_ms, output ready);
endinterface

FILE: src/rgai_result_if.sv
// Result item channel of the rate gyro angle integrator.
// Depends on rgai_pkg.
interface rgai_result_if;
	import rgai_pkg::*;

	logic               valid;
	logic               ready;
	logic [ANGLE_W-1:0] angle;
	logic               calibrated;

	modport source(output valid, angle, calibrated, input ready);
	modport sink(input valid, angle, calibrated, output ready);
endinterface

FILE: src/rgai_cfg_if.sv
// Configuration write channel of the rate gyro angle integrator.
// Depends on rgai_pkg.
interface rgai_cfg_if;
	import rgai_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [GAIN_W-1:0]    data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

FILE: src/rate_gyro_angle_integrator.sv
// Rate gyro angle integrator top level; uses rgai_pkg, the three channel interfaces
// and rate_gyro_angle_integrator_macros.svh.
// A measure item runs two bit-serial multiply passes and the calibrate item that
// completes the set runs a bit-serial divide; other items need neither.
// One item is in flight at a time; the next can be taken in the cycle after its result is staged.
// arst_n returns the sequencer to idle and clears all other registers to zero; the output register is one deep.
module rate_gyro_angle_integrator (
	input  logic clk,
	input  logic arst_n,
	rgai_item_if.sink   item,
	rgai_result_if.source result,
	rgai_cfg_if.sink    cfg
);
	import rgai_pkg::*;

	`include "rate_gyro_angle_integrator_macros.svh"

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PREP = 8'b0000_0010,
		ST_MUL1 = 8'b0000_0100,
		ST_MUL2 = 8'b0000_1000,
		ST_ACC  = 8'b0001_0000,
		ST_WRAP = 8'b0010_0000,
		ST_DIV  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [DBAND_W-1:0]  dead_band_q;
	logic [GAIN_W-1:0]   rate_gain_q;
	logic [1:0]          cmd_q;
	logic [SAMPLE_W-1:0] smp_q;
	logic [TICK_W-1:0]   tick_q;
	logic [SUM_W-1:0]    cal_sum_q;
	logic [CAL_W-1:0]    cal_count_q;
	logic [ZERO_W-1:0]   zero_q;
	logic [TICK_W-1:0]   prev_tick_q;
	logic [ANGLE_W-1:0]  angle_q;
	logic [PROD_W-1:0]   prod_q;
	logic [MCAND_W-1:0]  mcand_q;
	logic                neg_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [ACC_W-1:0]    sum_q;
	logic [DIVD_W-1:0]   divd_q;
	logic [CAL_W-1:0]    rem_q;
	logic                out_valid_q;
	logic [ANGLE_W-1:0]  out_angle_q;
	logic                out_cal_q;

	// Handshakes.
	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready  = 1'b1;
	assign result.valid      = out_valid_q;
	assign result.angle      = out_angle_q;
	assign result.calibrated = out_cal_q;

	// The result is staged once the output register is free.
	logic stage_out;
	assign stage_out = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	logic is_cal;
	assign is_cal = (cal_count_q == CAL_W'(CAL_SAMPLES));

	// Rate from sample and zero offset, with the dead band.
	logic [SAMPLE_W:0]   diff;
	logic [SAMPLE_W-1:0] adiff;
	logic                in_band;
	logic [ZERO_W:0]     fine;
	logic [ZERO_W-1:0]   afine;
	logic [RATE_W-1:0]   rate_mag;
	always_comb begin
		diff     = {1'b0, smp_q} - {1'b0, zero_q[ZERO_W-1:FRAC_W]};
		adiff    = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
		in_band  = (adiff <= dead_band_q);
		fine     = {1'b0, smp_q, FRAC_W'(0)} - {1'b0, zero_q};
		afine    = fine[ZERO_W] ? ZERO_W'(-fine) : fine[ZERO_W-1:0];
		rate_mag = in_band ? '0 : afine[ZERO_W-1:FRAC_W];
	end

	// Elapsed ticks, saturated.
	logic [TICK_W-1:0] dtick;
	logic [DT_W-1:0]   dt;
	always_comb begin
		dtick = tick_q - prev_tick_q;
		dt    = (dtick[TICK_W-1:DT_W] != '0) ? '1 : dtick[DT_W-1:0];
	end

	// Calibration sum and count after this sample.
	logic [SUM_W-1:0] sum_nxt;
	logic [CAL_W-1:0] count_nxt;
	assign sum_nxt   = cal_sum_q + SUM_W'(smp_q);
	assign count_nxt = cal_count_q + 1'b1;

	// One step of the shift-add multiplier: add at the top, shift right.
	logic [MCAND_W:0]  part;
	logic [PROD_W-1:0] prod_nxt;
	always_comb begin
		part     = {1'b0, prod_q[PROD_W-1:GAIN_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
		prod_nxt = {part, prod_q[GAIN_W-1:1]};
	end

	// Magnitude shifted and clamped below a full turn; signed sum with the angle.
	logic [ANGLE_W-1:0] mag;
	logic [ACC_W-1:0]   sum_d;
	always_comb begin
		if ((prod_q[PROD_W-1:MAG_SH+ANGLE_W] != '0) ||
		    (prod_q[MAG_SH+ANGLE_W-1:MAG_SH] > FULL_TURN - 1'b1)) begin
			mag = FULL_TURN - 1'b1;
		end else begin
			mag = prod_q[MAG_SH+ANGLE_W-1:MAG_SH];
		end
		if (neg_q) begin
			sum_d = {2'b00, angle_q} - {2'b00, mag};
		end else begin
			sum_d = {2'b00, angle_q} + {2'b00, mag};
		end
	end

	// One step of the restoring divider by the sample count.
	logic [CAL_W:0]    trial;
	logic              q_bit;
	logic [DIVD_W-1:0] divd_nxt;
	always_comb begin
		trial    = {rem_q, divd_q[DIVD_W-1]};
		q_bit    = (trial >= (CAL_W + 1)'(CAL_SAMPLES));
		divd_nxt = {divd_q[DIVD_W-2:0], q_bit};
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_band_q <= '0;
			rate_gain_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEAD_BAND: dead_band_q <= cfg.data[DBAND_W-1:0];
				REG_RATE_GAIN: rate_gain_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer, state and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			smp_q       <= '0;
			tick_q      <= '0;
			cal_sum_q   <= '0;
			cal_count_q <= '0;
			zero_q      <= '0;
			prev_tick_q <= '0;
			angle_q     <= '0;
			prod_q      <= '0;
			mcand_q     <= '0;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			sum_q       <= '0;
			divd_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			out_angle_q <= '0;
			out_cal_q   <= 1'b0;
		end else begin
			// Output register: load a new result, or empty it when taken.
			if (stage_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						cmd_q   <= item.cmd;
						smp_q   <= item.sample;
						tick_q  <= item.tick_ms;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					unique case (cmd_q)
						CMD_CAL: begin
							if (!is_cal) begin
								cal_sum_q   <= sum_nxt;
								cal_count_q <= count_nxt;
								if (count_nxt == CAL_W'(CAL_SAMPLES)) begin
									angle_q <= '0;
									divd_q  <= {sum_nxt, FRAC_W'(0)};
									rem_q   <= '0;
									cnt_q   <= '0;
									state_q <= ST_DIV;
								end else begin
									state_q <= ST_DONE;
								end
							end else begin
								state_q <= ST_DONE;
							end
						end
						CMD_MEASURE: begin
							prev_tick_q <= tick_q;
							prod_q      <= PROD_W'(rate_mag);
							mcand_q     <= MCAND_W'(dt);
							neg_q       <= fine[ZERO_W];
							cnt_q       <= '0;
							state_q     <= ST_MUL1;
						end
						CMD_CLEAR: begin
							angle_q <= '0;
							state_q <= ST_DONE;
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_MUL1: begin
					if (cnt_q == CNT_W'(RATE_W - 1)) begin
						mcand_q <= prod_nxt[P1_LO+MCAND_W-1:P1_LO];
						prod_q  <= PROD_W'(rate_gain_q);
						cnt_q   <= '0;
						state_q <= ST_MUL2;
					end else begin
						prod_q <= prod_nxt;
						cnt_q  <= cnt_q + 1'b1;
					end
				end
				ST_MUL2: begin
					prod_q <= prod_nxt;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(GAIN_W - 1)) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					sum_q   <= sum_d;
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					// Below zero adds a turn, above a full turn drops one.
					if (sum_q[ACC_W-1]) begin
						angle_q <= sum_q[ANGLE_W-1:0] + FULL_TURN;
					end else if (sum_q > {2'b00, FULL_TURN}) begin
						angle_q <= sum_q[ANGLE_W-1:0] - FULL_TURN;
					end else begin
						angle_q <= sum_q[ANGLE_W-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DIV: begin
					divd_q <= divd_nxt;
					rem_q  <= q_bit ? CAL_W'(trial - (CAL_W + 1)'(CAL_SAMPLES))
					                : trial[CAL_W-1:0];
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIVD_W - 1)) begin
						zero_q  <= divd_nxt[ZERO_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Stage the result once the output register is free.
					if (stage_out) begin
						out_angle_q <= angle_q;
						out_cal_q   <= is_cal;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Checks on the angle range, calibration and the divide pass.
	`RGAI_ASSERT_NOW(a_angle_range, out_valid_q, out_angle_q <= FULL_TURN, "angle above full turn")
	`RGAI_ASSERT_NEXT(a_cal_sticky, is_cal, is_cal, "calibration lost")
	`RGAI_ASSERT_NOW(a_div_cal, state_q == ST_DIV, is_cal && angle_q == '0, "divide without full calibration")

endmodule

FILE: verif/rgai_angle_checker.sv
// Scoreboard for the rate gyro angle integrator: watches the item, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on rgai_pkg and the three channel interfaces.
module rgai_angle_checker
	import rgai_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	rgai_item_if   item,
	rgai_result_if result,
	rgai_cfg_if    cfg,
	output int     mismatches,
	output int     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint unsigned u64_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic               calibrated;
	} angle_result_t;

	localparam int                MAX_REPORTS = 10;
	localparam logic [TICK_W-1:0] DT_SAT      = 65535;
	localparam longint            TURN        = longint'(FULL_TURN);
	localparam u64_t              TURN_MAX    = u64_t'(FULL_TURN) - 1;

	// Shadow copy of the registers and the integrator state.
	logic [DBAND_W-1:0] band_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [SUM_W-1:0]   cal_sum_q;
	logic [CAL_W-1:0]   count_q;
	logic [ZERO_W-1:0]  zero_q;
	logic [TICK_W-1:0]  prev_tick_q;
	logic [ANGLE_W-1:0] angle_q;

	angle_result_t expected_q[$];
	int fail_cnt  = 0;
	int result_no = 0;

	task automatic note_failure(input string text);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS) begin
			$display("%t result %0d: %s", $time, result_no, text);
		end
	endtask

	// Advance the shadow state by one item and queue the angle it leaves behind.
	task automatic integrate_item(input logic [1:0] op, input logic [SAMPLE_W-1:0] s,
			input logic [TICK_W-1:0] t);
		int                floor_zero;
		int                offset;
		int                rate;
		logic [TICK_W-1:0] dt;
		u64_t              mag;
		longint            sum;
		angle_result_t     res;
		case (op)
			CMD_CAL: begin
				// Samples past the full set are ignored until the next reset.
				if (count_q != CAL_W'(CAL_SAMPLES)) begin
					cal_sum_q = cal_sum_q + SUM_W'(s);
					count_q = count_q + 1'b1;
					if (count_q == CAL_W'(CAL_SAMPLES)) begin
						zero_q = ZERO_W'((u64_t'(cal_sum_q) << FRAC_W) / CAL_SAMPLES);
						angle_q = '0;
					end
				end
			end
			CMD_MEASURE: begin
				// Dead band is judged against the integer part of the offset.
				floor_zero = int'(zero_q >> FRAC_W);
				offset = int'(s) - floor_zero;
				if (offset < 0) offset = -offset;
				rate = 0;
				if (offset > int'(band_q)) begin
					rate = (int'(s) * 256 - int'(zero_q)) / 256;
				end
				// Modular tick difference, saturated.
				dt = t - prev_tick_q;
				if (dt > DT_SAT) dt = DT_SAT;
				prev_tick_q = t;
				mag = u64_t'(rate < 0 ? -rate : rate) * u64_t'(dt);
				mag = (mag * u64_t'(gain_q)) >> MAG_SH;
				if (mag > TURN_MAX) mag = TURN_MAX;
				// One correction into [0, 360]; exactly 360 is kept.
				sum = longint'(angle_q) + (rate < 0 ? -longint'(mag) : longint'(mag));
				if (sum > TURN) sum = sum - TURN;
				if (sum < 0) sum = sum + TURN;
				angle_q = ANGLE_W'(sum);
			end
			CMD_CLEAR: begin
				angle_q = '0;
			end
			default: begin
			end
		endcase
		res.angle = angle_q;
		res.calibrated = (count_q == CAL_W'(CAL_SAMPLES));
		expected_q.push_back(res);
	endtask

	// Register writes, result comparison and prediction, all on the sampling edge.
	always @(posedge clk or negedge arst_n) begin
		angle_result_t want;
		if (!arst_n) begin
			band_q      = '0;
			gain_q      = '0;
			cal_sum_q   = '0;
			count_q     = '0;
			zero_q      = '0;
			prev_tick_q = '0;
			angle_q     = '0;
			expected_q.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DEAD_BAND: band_q = cfg.data[DBAND_W-1:0];
					REG_RATE_GAIN: gain_q = cfg.data;
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready) begin
				result_no++;
				if (expected_q.size() == 0) begin
					note_failure($sformatf("unexpected item: angle %0d calibrated %0b",
						result.angle, result.calibrated));
				end else begin
					want = expected_q.pop_front();
					if (result.angle !== want.angle) begin
						note_failure($sformatf("angle expected %0d, got %0d",
							want.angle, result.angle));
					end
					if (result.calibrated !== want.calibrated) begin
						note_failure($sformatf("calibrated expected %0b, got %0b",
							want.calibrated, result.calibrated));
					end
				end
			end
			if (item.valid && item.ready) begin
				integrate_item(item.cmd, item.sample, item.tick_ms);
			end
		end
		mismatches  <= fail_cnt;
		outstanding <= expected_q.size();
	end

endmodule

FILE: verif/tb_rate_gyro_angle_integrator.sv
// Testbench top for the rate gyro angle integrator: clock, reset, directed and
// random gyro samples, register phases and the verdict.
// Depends on rgai_pkg, the channel interfaces, rgai_angle_checker and the block.
module tb_rate_gyro_angle_integrator;
	timeunit 1ns;
	timeprecision 1ps;
	import rgai_pkg::*;

	localparam int         CLK_HALF      = 4;
	localparam int         RESET_CYCLES  = 5;
	localparam int         IDLE_LIMIT    = 2000;
	localparam int         TAIL_CYCLES   = 64;
	localparam int         RANDOM_PHASES = 8;
	localparam int         PHASE_ITEMS   = 135;
	localparam int         SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
	localparam logic [1:0] CMD_UNUSED    = 2'd3;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	rgai_item_if   item_ch();
	rgai_result_if result_ch();
	rgai_cfg_if    cfg_ch();

	int mismatches;
	int outstanding;

	// Stimulus bookkeeping shared by the drivers.
	bit                steady     = 1'b0;
	logic [TICK_W-1:0] last_tick  = '0;
	int                cal_taken  = 0;
	int                band_cur   = 0;
	int                cal_center = 0;
	int                idle_cycles = 0;

	rate_gyro_angle_integrator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	rgai_angle_checker checker_inst (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.cfg         (cfg_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #CLK_HALF clk = ~clk;

	// Idle length: mostly none or short, now and then long; none in a steady phase.
	function automatic int pick_gap();
		int roll;
		if (steady) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side back-pressure.
	always begin
		int stall;
		int hold;
		stall = pick_gap();
		if (stall > 0) begin
			result_ch.ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
		result_ch.ready <= 1'b1;
		hold = $urandom_range(1, 8);
		repeat (hold) @(posedge clk);
	end

	// Watchdog on cycles with no handshake on any channel.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_rate_gyro_angle_integrator: done, errors");
			$finish;
		end
	end

	// Offer one item; valid stays high into the next item unless a gap is taken.
	task automatic send_sample(input logic [1:0] op, input logic [SAMPLE_W-1:0] s,
			input logic [TICK_W-1:0] t);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.cmd     <= op;
		item_ch.sample  <= s;
		item_ch.tick_ms <= t;
		do @(posedge clk); while (!item_ch.ready);
		if (op == CMD_MEASURE) last_tick = t;
		if (op == CMD_CAL && cal_taken < CAL_SAMPLES) cal_taken++;
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [GAIN_W-1:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			cfg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_regs(input int band, input logic [GAIN_W-1:0] gain);
		write_reg(REG_DEAD_BAND, GAIN_W'(band));
		write_reg(REG_RATE_GAIN, gain);
		cfg_ch.valid <= 1'b0;
		band_cur = band;
	endtask

	// Stop offering items and wait until every result has been taken.
	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int                phase;
		int                counted;
		int                roll;
		int                pick;
		int                cal_pct;
		int                aim;
		int                offset;
		int                zero_est;
		int                band;
		logic [1:0]        op;
		logic [SAMPLE_W-1:0] s;
		logic [TICK_W-1:0] t;
		logic [GAIN_W-1:0] gain;

		item_ch.valid   <= 1'b0;
		item_ch.cmd     <= CMD_CLEAR;
		item_ch.sample  <= '0;
		item_ch.tick_ms <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= REG_DEAD_BAND;
		cfg_ch.data     <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Widest dead band with zero gain: nothing moves.
		set_regs(SAMPLE_MAX, '0);
		send_sample(CMD_MEASURE, SAMPLE_W'(SAMPLE_MAX), 32'd0);
		wait_drained();

		// Before calibration the offset is zero; full gain drives the clamp.
		set_regs(0, '1);
		send_sample(CMD_MEASURE, '0, 32'd0);
		send_sample(CMD_MEASURE, SAMPLE_W'(SAMPLE_MAX), 32'd1);
		send_sample(CMD_CLEAR, SAMPLE_W'(SAMPLE_MAX), 32'hFFFF_FFFF);
		// Long interval saturates dt, then a counter wrap gives a short one.
		send_sample(CMD_MEASURE, 12'd1, 32'hFFFF_FFF0);
		send_sample(CMD_MEASURE, 12'd2, 32'h0000_0005);
		// Tick running backwards.
		send_sample(CMD_MEASURE, SAMPLE_W'(SAMPLE_MAX), 32'd3);
		send_sample(CMD_UNUSED, SAMPLE_W'(SAMPLE_MAX), 32'hFFFF_FFFF);
		send_sample(CMD_CLEAR, '0, 32'd0);
		send_sample(CMD_MEASURE, SAMPLE_W'(SAMPLE_MAX), 32'd4);
		wait_drained();

		// One count lands the angle on exactly 360, the next wraps it.
		set_regs(0, 32'd256);
		send_sample(CMD_MEASURE, 12'd1, 32'd5);
		send_sample(CMD_MEASURE, 12'd1, 32'd6);
		send_sample(CMD_MEASURE, SAMPLE_W'(SAMPLE_MAX), 32'd6);
		send_sample(CMD_CAL, SAMPLE_W'(SAMPLE_MAX), 32'd0);
		send_sample(CMD_CAL, '0, 32'hFFFF_FFFF);
		wait_drained();

		// Dead band edge: inside, then just outside.
		set_regs(1, 32'h0040_0000);
		send_sample(CMD_MEASURE, 12'd1, 32'd7);
		send_sample(CMD_MEASURE, 12'd2, 32'd8);

		// Random phases, each with its own register setting.
		cal_center = $urandom_range(200, 3900);
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			case ($urandom_range(0, 4))
				0: band = 0;
				1: band = SAMPLE_MAX;
				2: band = $urandom_range(1, 15);
				3: band = $urandom_range(16, 300);
				default: band = $urandom_range(0, SAMPLE_MAX);
			endcase
			case ($urandom_range(0, 4))
				0: gain = '0;
				1: gain = '1;
				2: gain = $urandom_range(1 << 16, 1 << 24);
				3: gain = $urandom;
				default: gain = $urandom_range(1 << 22, 1 << 26);
			endcase
			set_regs(band, gain);
			steady = ($urandom_range(0, 3) == 0);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				// Calibrate items are frequent until the set is complete.
				cal_pct = (cal_taken >= CAL_SAMPLES) ? 3 : 35;
				roll = $urandom_range(0, 99);
				if (roll < cal_pct) op = CMD_CAL;
				else if (roll < cal_pct + 5) op = CMD_CLEAR;
				else if (roll < cal_pct + 7) op = CMD_UNUSED;
				else op = CMD_MEASURE;

				zero_est = (cal_taken >= CAL_SAMPLES) ? cal_center : 0;
				pick = $urandom_range(0, 99);
				if (op == CMD_CAL) begin
					if (pick < 10) aim = $urandom_range(0, SAMPLE_MAX);
					else aim = cal_center + $urandom_range(0, 128) - 64;
				end else if (op == CMD_MEASURE) begin
					// Aim at the dead band edge, near the offset, or anywhere.
					if (pick < 40) begin
						offset = band_cur + $urandom_range(0, 3) - 1;
						if ($urandom_range(0, 1)) offset = -offset;
						aim = zero_est + offset;
					end else if (pick < 80) begin
						aim = zero_est + $urandom_range(0, 600) - 300;
					end else if (pick < 85) begin
						aim = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
					end else begin
						aim = $urandom_range(0, SAMPLE_MAX);
					end
				end else begin
					aim = $urandom_range(0, SAMPLE_MAX);
				end
				if (aim < 0) aim = 0;
				if (aim > SAMPLE_MAX) aim = SAMPLE_MAX;
				s = SAMPLE_W'(aim);

				// Mostly short steady intervals; some long, saturating or backwards.
				pick = $urandom_range(0, 99);
				if (op != CMD_MEASURE) t = $urandom;
				else if (pick < 70) t = last_tick + $urandom_range(0, 10);
				else if (pick < 80) t = last_tick + $urandom_range(11, 70000);
				else if (pick < 88) t = last_tick + $urandom_range(65534, 65537);
				else if (pick < 94) t = last_tick - $urandom_range(1, 1000);
				else t = $urandom;

				// Ignored items do not count toward the phase length.
				if ((op == CMD_CAL && cal_taken < CAL_SAMPLES) ||
						op == CMD_MEASURE || op == CMD_CLEAR) begin
					counted++;
				end
				send_sample(op, s, t);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_rate_gyro_angle_integrator: done, clean");
		end else begin
			$display("tb_rate_gyro_angle_integrator: done, errors");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/rgai_pkg.sv
src/rgai_item_if.sv
src/rgai_result_if.sv
src/rgai_cfg_if.sv
src/rate_gyro_angle_integrator.sv
verif/rgai_angle_checker.sv
verif/tb_rate_gyro_angle_integrator.sv
